>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator: request modes,
// sequencer states and the control/flag bundles of the shared add/compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // fixed widths of the item fields
  localparam int MODE_W  = 2;
  localparam int FIELD_W = 10;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  // constant term added (or subtracted) by the shared unit
  typedef enum logic [1:0] {
    CST_NONE,
    CST_HDR,
    CST_HDR_SLACK
  } cst_t;

  // shared unit control
  typedef struct packed {
    cst_t cst;
    logic neg;
  } alu_ctl_t;

  // shared unit compare results
  typedef struct packed {
    logic ge;
    logic eq;
  } alu_flags_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_BOOT,
    S_IDLE,
    S_HINIT,
    S_A_RD,
    S_A_FIT,
    S_A_NEXT,
    S_A_SPLIT,
    S_A_NP,
    S_A_REM,
    S_A_SHRINK,
    S_A_MARK,
    S_R_RD,
    S_R_CHK,
    S_R_NEXT,
    S_R_MARK,
    S_C_RD,
    S_C_CUR,
    S_C_NX,
    S_C_NRD,
    S_C_NCHK,
    S_C_WR,
    S_PAY,
    S_OK,
    S_FAIL
  } state_t;

endpackage

`default_nettype wire

>>> rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ffha_alu.sv
// ----------------------------------------------------------------------------
// ffha_alu
// Shared add/subtract and compare unit: sum = a +/- b +/- constant, then the
// sum is compared against a third operand.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_alu import ffha_pkg::*; #(
  parameter int CW              = 12,
  parameter int HEADER_BYTES    = 24,
  parameter int MIN_SPLIT_SLACK = 8
) (
  input  wire logic [CW-1:0] a,
  input  wire logic [CW-1:0] b,
  input  wire logic [CW-1:0] cmp,
  input  wire alu_ctl_t      ctl,
  output logic      [CW-1:0] sum,
  output alu_flags_t         flags
);

  localparam logic [CW-1:0] K_HDR       = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] K_HDR_SLACK = CW'(HEADER_BYTES + MIN_SPLIT_SLACK);

  logic [CW-1:0] k;

  // constant term
  always_comb begin
    case (ctl.cst)
      CST_NONE:      k = '0;
      CST_HDR:       k = K_HDR;
      CST_HDR_SLACK: k = K_HDR_SLACK;
      default:       k = '0;
    endcase
  end

  // add or subtract, then compare
  always_comb begin
    if (ctl.neg) begin
      sum = a - b - k;
    end else begin
      sum = a + b + k;
    end
    flags.ge = (cmp >= sum);
    flags.eq = (cmp == sum);
  end

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over a chain of block headers kept in one RAM,
// with splitting on allocate and merging of free neighbors on release.
// ----------------------------------------------------------------------------
// Usage: pulse start with a request while busy is low; busy stays high until
// the item is finished, and the result shows on ok/payload_offset for exactly
// one cycle with done high, which the receiver must take. An allocate walks
// the blocks until one fits, then splits it or marks it used; a release
// walks to the target block, marks it free, then makes a merge pass over
// the chain; initialize rewrites the first header; a null release or an
// unused mode answers without a walk.
// The walk reads one header from the RAM per step (registered read data)
// and does its arithmetic in the single shared adder/comparator.
// After reset the block is busy for one cycle while it writes the first
// header.
`default_nettype none

module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int HEAP_BYTES      = 1024,
  parameter int HEADER_BYTES    = 24,
  parameter int MIN_SPLIT_SLACK = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [FIELD_W-1:0] request_size,
  input  wire logic [FIELD_W-1:0] release_offset,
  input  wire logic               release_is_null,
  output logic                    done,
  output logic                    ok,
  output logic [FIELD_W-1:0]      payload_offset
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int SW = (AW > FIELD_W) ? AW : FIELD_W;
  localparam int CW = SW + 2;
  localparam int DW = AW + 1;

  localparam logic [CW-1:0] HEAP_LAST  = CW'(HEAP_BYTES - 1);
  localparam logic [AW-1:0] FULL_SIZE  = AW'(HEAP_BYTES - HEADER_BYTES);

  state_t state, state_next;

  // walk registers
  logic [AW-1:0]      pos;
  logic [AW-1:0]      nx;
  logic [AW-1:0]      np;
  logic [AW-1:0]      cur_size;
  logic               cur_free;
  logic [FIELD_W-1:0] req;
  logic [FIELD_W-1:0] off;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [AW-1:0] rd_size;
  logic          rd_free;

  // shared unit
  logic [CW-1:0] alu_a;
  logic [CW-1:0] alu_b;
  logic [CW-1:0] alu_cmp;
  alu_ctl_t      alu_ctl;
  logic [CW-1:0] alu_sum;
  alu_flags_t    alu_flags;

  logic [CW-1:0] req_cw;

  assign rd_size = ram_rdata[AW-1:0];
  assign rd_free = ram_rdata[AW];
  assign req_cw  = CW'(req);
  assign busy    = (state != S_IDLE);

  ffha_ram #(
    .WIDTH (DW),
    .DEPTH (HEAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffha_alu #(
    .CW              (CW),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_SPLIT_SLACK (MIN_SPLIT_SLACK)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .cmp   (alu_cmp),
    .ctl   (alu_ctl),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_BOOT:     state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (mode_t'(mode))
            MODE_INIT:    state_next = S_HINIT;
            MODE_ALLOC:   state_next = S_A_RD;
            MODE_RELEASE: state_next = release_is_null ? S_OK : S_R_RD;
            default:      state_next = S_FAIL;
          endcase
        end
      end
      S_HINIT:    state_next = S_OK;
      S_A_RD:     state_next = S_A_FIT;
      S_A_FIT:    state_next = (rd_free && alu_flags.ge) ? S_A_SPLIT : S_A_NEXT;
      S_A_NEXT:   state_next = alu_flags.ge ? S_A_RD : S_FAIL;
      S_A_SPLIT:  state_next = alu_flags.ge ? S_A_NP : S_A_MARK;
      S_A_NP:     state_next = alu_flags.ge ? S_A_REM : S_A_MARK;
      S_A_REM:    state_next = S_A_SHRINK;
      S_A_SHRINK: state_next = S_PAY;
      S_A_MARK:   state_next = S_PAY;
      S_R_RD:     state_next = S_R_CHK;
      S_R_CHK:    state_next = alu_flags.eq ? S_R_MARK : S_R_NEXT;
      S_R_NEXT:   state_next = alu_flags.ge ? S_R_RD : S_FAIL;
      S_R_MARK:   state_next = S_C_RD;
      S_C_RD:     state_next = S_C_CUR;
      S_C_CUR:    state_next = S_C_NX;
      S_C_NX:     state_next = alu_flags.ge ? S_C_NRD : S_OK;
      S_C_NRD:    state_next = S_C_NCHK;
      S_C_NCHK:   state_next = (cur_free && rd_free) ? S_C_WR : S_C_NX;
      S_C_WR:     state_next = S_C_NX;
      S_PAY:      state_next = S_IDLE;
      S_OK:       state_next = S_IDLE;
      S_FAIL:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory and shared unit operands per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = {cur_free, cur_size};
    ram_raddr = pos;
    alu_a     = CW'(pos);
    alu_b     = '0;
    alu_cmp   = HEAP_LAST;
    alu_ctl   = '{cst: CST_NONE, neg: 1'b0};
    case (state)
      S_BOOT, S_HINIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, FULL_SIZE};
      end
      S_A_FIT: begin
        // does the free block hold the request
        alu_a   = req_cw;
        alu_cmp = CW'(rd_size);
      end
      S_A_NEXT, S_R_NEXT, S_C_NX: begin
        // next block offset, in range when it stays below the heap end
        alu_b       = CW'(cur_size);
        alu_ctl.cst = CST_HDR;
      end
      S_A_SPLIT: begin
        // remainder big enough for a header plus slack
        alu_a       = req_cw;
        alu_cmp     = CW'(cur_size);
        alu_ctl.cst = CST_HDR_SLACK;
      end
      S_A_NP: begin
        // offset of the split-off block
        alu_b       = req_cw;
        alu_ctl.cst = CST_HDR;
      end
      S_A_REM: begin
        // write the split-off free block
        alu_a     = CW'(cur_size);
        alu_b     = req_cw;
        alu_ctl   = '{cst: CST_HDR, neg: 1'b1};
        ram_we    = 1'b1;
        ram_waddr = np;
        ram_wdata = {1'b1, alu_sum[AW-1:0]};
      end
      S_A_SHRINK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, req_cw[AW-1:0]};
      end
      S_A_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, cur_size};
      end
      S_R_CHK: begin
        // payload of this block matches the released offset
        alu_cmp     = CW'(off);
        alu_ctl.cst = CST_HDR;
      end
      S_R_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, cur_size};
      end
      S_C_NRD: begin
        ram_raddr = nx;
      end
      S_C_NCHK: begin
        // merged size of two free neighbors
        alu_a       = CW'(cur_size);
        alu_b       = CW'(rd_size);
        alu_ctl.cst = CST_HDR;
      end
      S_C_WR: begin
        ram_we = 1'b1;
      end
      S_PAY: begin
        alu_ctl.cst = CST_HDR;
      end
      default: begin
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_PAY) || (state == S_OK) || (state == S_FAIL);
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pos <= '0;
        req <= request_size;
        off <= release_offset;
      end
      S_A_FIT, S_R_CHK, S_C_CUR: begin
        cur_size <= rd_size;
        cur_free <= rd_free;
      end
      S_A_NEXT, S_R_NEXT: begin
        if (alu_flags.ge) begin
          pos <= alu_sum[AW-1:0];
        end
      end
      S_A_NP: begin
        np <= alu_sum[AW-1:0];
      end
      S_R_MARK: begin
        pos <= '0;
      end
      S_C_NX: begin
        nx <= alu_sum[AW-1:0];
      end
      S_C_NCHK: begin
        if (cur_free && rd_free) begin
          cur_size <= alu_sum[AW-1:0];
        end else begin
          pos      <= nx;
          cur_size <= rd_size;
          cur_free <= rd_free;
        end
      end
      default: begin
      end
    endcase

    // result of the finished item
    case (state)
      S_PAY: begin
        ok             <= 1'b1;
        payload_offset <= alu_sum[FIELD_W-1:0];
      end
      S_OK: begin
        ok             <= 1'b1;
        payload_offset <= '0;
      end
      S_FAIL: begin
        ok             <= 1'b0;
        payload_offset <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> dv/first_fit_heap_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking testbench for the first-fit heap allocator. A scoreboard
// keeps its own copy of the block chain, predicts ok/payload_offset for
// every accepted item and checks each done strobe against the oldest
// prediction. A directed opening hits empty/full heap, split boundaries,
// re-release, null and bogus releases and the unused mode. Random phases
// then mix allocate, release, init and unused-mode traffic under several sender idle rates.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int HEAP_BYTES      = 1024;
  localparam int HEADER_BYTES    = 24;
  localparam int MIN_SPLIT_SLACK = 8;
  localparam int RANDOM_ITEMS    = 1700;
  localparam int SETTLE_CYCLES   = 400;

  // mode code the block has no operation for
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] payload;
  } answer_t;

  // chain model plus queue of predicted answers
  class heap_scoreboard;
    int unsigned blk_size [HEAP_BYTES];
    bit          blk_free [HEAP_BYTES];
    answer_t     pending_answers [$];
    int errors;
    int results_seen;
    int n_init, n_alloc_ok, n_alloc_fail, n_rel_ok, n_rel_rejected, n_null, n_unused;

    function new();
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_free[i] = 0;
      end
      format_heap();
    endfunction

    function void format_heap();
      blk_size[0] = HEAP_BYTES - HEADER_BYTES;
      blk_free[0] = 1;
    endfunction

    // start of the following block, or heap end
    function int unsigned next_block_at(int unsigned pos);
      int unsigned n;
      n = pos + HEADER_BYTES + blk_size[pos];
      return (n >= HEAP_BYTES) ? HEAP_BYTES : n;
    endfunction

    function void merge_free_runs();
      int unsigned pos;
      int unsigned nx;
      pos = 0;
      while (pos < HEAP_BYTES) begin
        nx = next_block_at(pos);
        if (nx >= HEAP_BYTES) break;
        if (blk_free[pos] && blk_free[nx])
          blk_size[pos] += HEADER_BYTES + blk_size[nx];
        else
          pos = nx;
      end
    endfunction

    // payload offset on success, -1 when nothing fits
    function int first_fit_alloc(int unsigned req);
      int unsigned pos;
      int unsigned np;
      pos = 0;
      while (pos < HEAP_BYTES) begin
        if (blk_free[pos] && blk_size[pos] >= req) begin
          if (blk_size[pos] >= req + HEADER_BYTES + MIN_SPLIT_SLACK) begin
            np = pos + HEADER_BYTES + req;
            if (np < HEAP_BYTES) begin
              blk_size[np] = blk_size[pos] - req - HEADER_BYTES;
              blk_free[np] = 1;
              blk_size[pos] = req;
            end
          end
          blk_free[pos] = 0;
          return pos + HEADER_BYTES;
        end
        pos = next_block_at(pos);
      end
      return -1;
    endfunction

    function bit release_block(int unsigned off);
      int unsigned pos;
      pos = 0;
      while (pos < HEAP_BYTES) begin
        if (pos + HEADER_BYTES == off) begin
          blk_free[pos] = 1;
          merge_free_runs();
          return 1;
        end
        pos = next_block_at(pos);
      end
      return 0;
    endfunction

    // predict the answer for an accepted item and queue it
    function answer_t note_request(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] req,
                                   logic [FIELD_W-1:0] roff, logic rnull);
      answer_t a;
      int      pay;
      a = '0;
      case (m)
        MODE_INIT: begin
          format_heap();
          a.ok = 1;
          n_init++;
        end
        MODE_ALLOC: begin
          pay = first_fit_alloc(req);
          if (pay >= 0) begin
            a.ok = 1;
            a.payload = pay[FIELD_W-1:0];
            n_alloc_ok++;
          end else begin
            n_alloc_fail++;
          end
        end
        MODE_RELEASE: begin
          if (rnull) begin
            a.ok = 1;
            n_null++;
          end else begin
            a.ok = release_block(roff);
            if (a.ok) n_rel_ok++;
            else n_rel_rejected++;
          end
        end
        default: n_unused++;
      endcase
      pending_answers.push_back(a);
      return a;
    endfunction

    function void check_result(logic ok_got, logic [FIELD_W-1:0] off_got);
      answer_t e;
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with no item outstanding: ok=%0d payload_offset=%0d",
               ok_got, off_got);
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      if (ok_got !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, ok_got);
        errors++;
      end
      if (off_got !== e.payload) begin
        $error("payload_offset: expected %0d, got %0d", e.payload, off_got);
        errors++;
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] release_offset;
  logic               release_is_null;
  logic               done;
  logic               ok;
  logic [FIELD_W-1:0] payload_offset;

  heap_scoreboard sb;
  int             idle_pct;
  int             live_offsets [$];
  int             stale_offsets [$];

  first_fit_heap_allocator #(
    .HEAP_BYTES(HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MIN_SPLIT_SLACK(MIN_SPLIT_SLACK)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .request_size(request_size),
    .release_offset(release_offset),
    .release_is_null(release_is_null),
    .done(done),
    .ok(ok),
    .payload_offset(payload_offset)
  );

  // clock
  initial clk = 0;
  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(ok, payload_offset);
  end

  // watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // present one item, hold it until accepted, then predict it
  task automatic send_item(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] req,
                           logic [FIELD_W-1:0] roff, logic rnull);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 0;
    end
    @(negedge clk);
    start = 1;
    mode = m;
    request_size = req;
    release_offset = roff;
    release_is_null = rnull;
    while (busy) @(negedge clk);
    @(posedge clk);
    a = sb.note_request(m, req, roff, rnull);
    if (m == MODE_ALLOC && a.ok) live_offsets.push_back(int'(a.payload));
    if (m == MODE_INIT) live_offsets.delete();
  endtask

  // let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    start = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic directed_items();
    // reset state, then edges of the empty and full heap
    send_item(MODE_ALLOC, 10'd1023, 10'd1023, 1'b1);
    send_item(MODE_INIT, 10'd1023, 10'd1023, 1'b1);
    send_item(MODE_ALLOC, 10'd1000, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd0, 10'd0, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd24, 1'b0);
    // release of a block that is already free
    send_item(MODE_RELEASE, 10'd0, 10'd24, 1'b0);
    send_item(MODE_RELEASE, 10'd1023, 10'd1023, 1'b1);
    // offset that is not a payload
    send_item(MODE_RELEASE, 10'd0, 10'd5, 1'b0);
    send_item(MODE_UNUSED, 10'd1023, 10'd1023, 1'b1);
    // split exactly at the slack boundary, then exact fit of the remainder
    send_item(MODE_INIT, 10'd0, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd968, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd8, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd0, 10'd0, 1'b0);
    // one byte short of a split
    send_item(MODE_INIT, 10'd0, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd969, 10'd0, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd24, 1'b0);
    // several blocks, freed out of order so neighbors merge
    send_item(MODE_ALLOC, 10'd0, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd100, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd200, 10'd0, 1'b0);
    send_item(MODE_ALLOC, 10'd300, 10'd0, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd48, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd24, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd172, 1'b0);
    send_item(MODE_ALLOC, 10'd150, 10'd0, 1'b0);
    send_item(MODE_RELEASE, 10'd0, 10'd1000, 1'b0);
  endtask

  task automatic random_items(int count);
    int r;
    int idx;
    int off;
    int unsigned sz;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_item(MODE_INIT, FIELD_W'($urandom_range(1023)),
                  FIELD_W'($urandom_range(1023)), 1'($urandom_range(1)));
      end else if (r < 5) begin
        send_item(MODE_UNUSED, FIELD_W'($urandom_range(1023)),
                  FIELD_W'($urandom_range(1023)), 1'($urandom_range(1)));
      end else if (r < 9) begin
        send_item(MODE_RELEASE, FIELD_W'($urandom_range(1023)),
                  FIELD_W'($urandom_range(1023)), 1'b1);
      end else if (r < 14) begin
        // arbitrary offset, mostly rejected
        send_item(MODE_RELEASE, FIELD_W'($urandom_range(1023)),
                  FIELD_W'($urandom_range(1023)), 1'b0);
      end else if (r < 19 && stale_offsets.size() > 0) begin
        // offset freed earlier: may be free, merged away or reused
        idx = $urandom_range(stale_offsets.size() - 1);
        send_item(MODE_RELEASE, FIELD_W'($urandom_range(1023)),
                  FIELD_W'(stale_offsets[idx]), 1'b0);
      end else if ((r < 55 && live_offsets.size() > 0) || live_offsets.size() > 24) begin
        idx = $urandom_range(live_offsets.size() - 1);
        off = live_offsets[idx];
        live_offsets.delete(idx);
        stale_offsets.push_back(off);
        if (stale_offsets.size() > 32) void'(stale_offsets.pop_front());
        send_item(MODE_RELEASE, FIELD_W'($urandom_range(1023)), FIELD_W'(off), 1'b0);
      end else begin
        r = $urandom_range(99);
        if (r < 70) sz = $urandom_range(63);
        else if (r < 90) sz = $urandom_range(255, 64);
        else sz = $urandom_range(1023, 256);
        send_item(MODE_ALLOC, FIELD_W'(sz), FIELD_W'($urandom_range(1023)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  // stimulus
  initial begin
    int phase_idle [4];
    phase_idle = '{0, 87, 0, 28};
    sb = new();
    rst = 1;
    start = 0;
    mode = MODE_INIT;
    request_size = '0;
    release_offset = '0;
    release_is_null = 0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed_items();
    drain_results();

    // random phases, each starting from an empty pipeline
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      random_items(RANDOM_ITEMS / 4);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d inits, %0d allocs (%0d without a fit), %0d releases",
             sb.n_init, sb.n_alloc_ok + sb.n_alloc_fail, sb.n_alloc_fail,
             sb.n_rel_ok + sb.n_rel_rejected + sb.n_null);
    $display("  %0d releases rejected, %0d null, %0d unused mode; %0d results checked",
             sb.n_rel_rejected, sb.n_null, sb.n_unused, sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
